### sv/m2sh_pkg.sv
package m2sh_pkg;

   // Stream words
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  field_code;
      logic [17:0] field_value;
      logic [5:0]  matrix_index;
      logic        last_result;
   } rsp_word_type;

   // Byte as it leaves the front queue, with its classification
   typedef struct packed {
      req_word_type word;
      logic         is_zero;
      logic         is_one;
      logic         is_seq_code;
      logic         is_ext_code;
   } front_item_type;

   localparam int MATRIX_ENTRIES = 64;
   localparam int MCOUNT_W       = 7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [7:0] SEQ_HEADER_CODE = 8'hB3;
   localparam logic [7:0] EXTENSION_CODE  = 8'hB5;
   localparam logic [17:0] SEQ_EXT_ID     = 18'd1;

   // Field codes
   localparam logic [4:0] CODE_START      = 5'd0;
   localparam logic [4:0] CODE_MARKER_ERR = 5'd22;
   localparam logic [4:0] CODE_BAD_EXT    = 5'd23;

   // Field positions inside the sequence header
   localparam logic [4:0] SEQ_POS_LOAD_INTRA    = 5'd8;
   localparam logic [4:0] SEQ_POS_INTRA         = 5'd9;
   localparam logic [4:0] SEQ_POS_LOAD_NONINTRA = 5'd10;
   localparam logic [4:0] SEQ_POS_NONINTRA      = 5'd11;
   localparam logic [4:0] SEQ_POS_COUNT         = 5'd12;

   // Field positions inside the sequence extension
   localparam logic [4:0] EXT_POS_ID     = 5'd0;
   localparam logic [4:0] EXT_POS_MARKER = 5'd7;
   localparam logic [4:0] EXT_POS_LAST   = 5'd10;
   localparam logic [4:0] EXT_POS_COUNT  = 5'd11;

   // Bit width of the field at a position; 1 outside the tables
   function automatic logic [4:0] field_width(input logic is_ext, input logic [4:0] pos);
      logic [4:0] w;
      w = 5'd1;
      if (!is_ext) begin
         unique case (pos)
            5'd0, 5'd1: w = 5'd12;
            5'd2, 5'd3: w = 5'd4;
            5'd4:       w = 5'd18;
            5'd6:       w = 5'd10;
            5'd9, 5'd11: w = 5'd8;
            default:    w = 5'd1;
         endcase
      end else begin
         unique case (pos)
            5'd0:             w = 5'd4;
            5'd1, 5'd8:       w = 5'd8;
            5'd3, 5'd4, 5'd5: w = 5'd2;
            5'd6:             w = 5'd12;
            5'd10:            w = 5'd7;
            default:          w = 5'd1;
         endcase
      end
      return w;
   endfunction

   // Result code of a sequence extension field
   function automatic logic [4:0] ext_field_code(input logic [4:0] pos);
      logic [4:0] c;
      unique case (pos)
         5'd1:    c = 5'd13;
         5'd2:    c = 5'd14;
         5'd3:    c = 5'd15;
         5'd4:    c = 5'd16;
         5'd5:    c = 5'd17;
         5'd6:    c = 5'd18;
         5'd8:    c = 5'd19;
         5'd9:    c = 5'd20;
         5'd10:   c = 5'd21;
         default: c = 5'd0;
      endcase
      return c;
   endfunction

endpackage

### sv/mpeg2_sequence_header_parser_top.sv
// Throughput: one byte per cycle while the byte queue is not full; a byte that completes
//   more than one field holds the field extractor until each of them has been emitted,
//   since it emits at most one field per cycle, and it stalls while the result queue is full.
// The 4-entry byte queue and 4-entry result queue let input and output stall independently.
// Reset is synchronous, active high: it empties both queues and puts the parser in hunting.
module mpeg2_sequence_header_parser_top (
   input  logic                   clock,
   input  logic                   reset,
   // byte stream in
   input  logic                   req_valid,
   output logic                   req_stall,
   input  m2sh_pkg::req_word_type req_word,
   // parsed fields out
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output m2sh_pkg::rsp_word_type rsp_word
);

   logic                     head_valid;
   m2sh_pkg::front_item_type head_item;
   logic                     head_pop;
   logic                     push;
   m2sh_pkg::rsp_word_type   push_word;
   logic                     out_full;

   // Front: takes stream words, tags zero / one / sequence header and extension start code bytes,
   // and buffers them so the back end can stay on one byte while it extracts its fields.
   m2sh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   // Back: start code hunt plus the MSB-first field extractor. Each cycle that it
   // is not stalled it consumes bits up to the end of the current field or byte, so
   // at most one field completes per cycle. The result is parked in a pending
   // register so that the last-of-byte flag can be set before it leaves.
   m2sh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .push       (push),
      .push_word  (push_word),
      .out_full   (out_full)
   );

   // Output queue: result words wait here while the consumer stalls.
   m2sh_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### sv/m2sh_front.sv
module m2sh_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  m2sh_pkg::req_word_type  req_word,
   output logic                    head_valid,
   output m2sh_pkg::front_item_type head_item,
   input  logic                    head_pop
);

   m2sh_pkg::front_item_type              mem_ff [m2sh_pkg::QUEUE_DEPTH];
   logic [m2sh_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [m2sh_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [m2sh_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   m2sh_pkg::front_item_type              item;
   logic                                  push;
   logic                                  pop;

   // classify the incoming byte
   always_comb begin
      item.word        = req_word;
      item.is_zero     = (req_word.data_byte == 8'h00);
      item.is_one      = (req_word.data_byte == 8'h01);
      item.is_seq_code = (req_word.data_byte == m2sh_pkg::SEQ_HEADER_CODE);
      item.is_ext_code = (req_word.data_byte == m2sh_pkg::EXTENSION_CODE);
   end

   assign req_stall  = (count_ff == m2sh_pkg::QUEUE_CNT_W'(m2sh_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### sv/m2sh_back.sv
module m2sh_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  m2sh_pkg::front_item_type head_item,
   output logic                     head_pop,
   output logic                     push,
   output m2sh_pkg::rsp_word_type   push_word,
   input  logic                     out_full
);

   typedef enum logic [3:0] {
      MODE_HUNT = 4'b0001,
      MODE_CODE = 4'b0010,
      MODE_SEQ  = 4'b0100,
      MODE_EXT  = 4'b1000
   } parse_mode_type;

   parse_mode_type                      mode_ff, mode_in;
   logic [1:0]                          zero_run_ff, zero_run_in;
   logic [17:0]                         acc_ff, acc_in;
   logic [4:0]                          bits_ff, bits_in;
   logic [4:0]                          pos_ff, pos_in;
   logic [m2sh_pkg::MCOUNT_W-1:0]       mcount_ff, mcount_in;
   logic [2:0]                          used_ff, used_in;

   logic                                pend_valid_ff, pend_valid_in;
   logic                                pend_done_ff, pend_done_in;
   m2sh_pkg::rsp_word_type              pend_word_ff, pend_word_in;

   logic                                step;
   logic                                can_push;
   logic                                new_res;
   m2sh_pkg::rsp_word_type              res_word;
   logic                                byte_done;
   logic                                hunt;
   logic [4:0]                          width;
   logic [4:0]                          need;
   logic [3:0]                          rem;
   logic [3:0]                          take;
   logic [7:0]                          chunk;
   logic [17:0]                         acc_new;
   logic [3:0]                          used_sum;
   logic                                complete;
   logic [m2sh_pkg::MCOUNT_W-1:0]       mcount_next;
   logic [7:0]                          data;

   assign data     = head_item.word.data_byte;
   assign can_push = !out_full;
   assign step     = head_valid && (!pend_valid_ff || can_push);

   // bit extraction: take up to the end of the current field or the byte
   always_comb begin
      width    = m2sh_pkg::field_width(mode_ff == MODE_EXT, pos_ff);
      need     = width - bits_ff;
      rem      = 4'd8 - {1'b0, used_ff};
      take     = (need <= {1'b0, rem}) ? need[3:0] : rem;
      chunk    = 8'(data << used_ff) >> (4'd8 - take);
      acc_new  = 18'((acc_ff << take) | {10'b0, chunk});
      used_sum = {1'b0, used_ff} + take;
      complete = ({1'b0, take} == need);
   end

   always_comb begin
      mode_in     = mode_ff;
      zero_run_in = zero_run_ff;
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      pos_in      = pos_ff;
      mcount_in   = mcount_ff;
      used_in     = used_ff;
      new_res     = 1'b0;
      res_word    = '0;
      byte_done   = 1'b0;
      hunt        = 1'b0;
      mcount_next = mcount_ff + 1'b1;

      unique case (mode_ff)
         MODE_HUNT: begin
            byte_done = 1'b1;
            if (head_item.is_zero) begin
               if (zero_run_ff != 2'd2) begin
                  zero_run_in = zero_run_ff + 1'b1;
               end
            end else if (head_item.is_one && zero_run_ff == 2'd2) begin
               mode_in     = MODE_CODE;
               zero_run_in = 2'd0;
            end else begin
               zero_run_in = 2'd0;
            end
         end
         MODE_CODE: begin
            byte_done            = 1'b1;
            new_res              = 1'b1;
            res_word.field_code  = m2sh_pkg::CODE_START;
            res_word.field_value = {10'b0, data};
            zero_run_in          = 2'd0;
            acc_in               = '0;
            bits_in              = '0;
            pos_in               = '0;
            mcount_in            = '0;
            if (head_item.is_seq_code) begin
               mode_in = MODE_SEQ;
            end else if (head_item.is_ext_code) begin
               mode_in = MODE_EXT;
            end else begin
               mode_in = MODE_HUNT;
            end
         end
         MODE_SEQ, MODE_EXT: begin
            if (!complete) begin
               acc_in  = acc_new;
               bits_in = bits_ff + 5'(take);
            end else begin
               acc_in  = '0;
               bits_in = '0;
               if (mode_ff == MODE_SEQ) begin
                  if (pos_ff < m2sh_pkg::SEQ_POS_COUNT) begin
                     new_res              = 1'b1;
                     res_word.field_code  = pos_ff + 5'd1;
                     res_word.field_value = acc_new;
                     if (pos_ff == m2sh_pkg::SEQ_POS_INTRA ||
                         pos_ff == m2sh_pkg::SEQ_POS_NONINTRA) begin
                        res_word.matrix_index = mcount_ff[5:0];
                        if (mcount_next >= m2sh_pkg::MCOUNT_W'(m2sh_pkg::MATRIX_ENTRIES)) begin
                           mcount_in = '0;
                           if (pos_ff == m2sh_pkg::SEQ_POS_NONINTRA) begin
                              hunt = 1'b1;
                           end else begin
                              pos_in = m2sh_pkg::SEQ_POS_LOAD_NONINTRA;
                           end
                        end else begin
                           mcount_in = mcount_next;
                        end
                     end else if (pos_ff == m2sh_pkg::SEQ_POS_LOAD_INTRA) begin
                        pos_in = (acc_new != '0) ? m2sh_pkg::SEQ_POS_INTRA
                                                 : m2sh_pkg::SEQ_POS_LOAD_NONINTRA;
                     end else if (pos_ff == m2sh_pkg::SEQ_POS_LOAD_NONINTRA) begin
                        if (acc_new != '0) begin
                           pos_in = m2sh_pkg::SEQ_POS_NONINTRA;
                        end else begin
                           hunt = 1'b1;
                        end
                     end else begin
                        pos_in = pos_ff + 5'd1;
                     end
                  end else begin
                     hunt = 1'b1;
                  end
               end else begin
                  if (pos_ff < m2sh_pkg::EXT_POS_COUNT) begin
                     if (pos_ff == m2sh_pkg::EXT_POS_ID) begin
                        if (acc_new != m2sh_pkg::SEQ_EXT_ID) begin
                           new_res              = 1'b1;
                           res_word.field_code  = m2sh_pkg::CODE_BAD_EXT;
                           res_word.field_value = acc_new;
                           hunt                 = 1'b1;
                        end else begin
                           pos_in = pos_ff + 5'd1;
                        end
                     end else if (pos_ff == m2sh_pkg::EXT_POS_MARKER) begin
                        if (acc_new == '0) begin
                           new_res             = 1'b1;
                           res_word.field_code = m2sh_pkg::CODE_MARKER_ERR;
                           hunt                = 1'b1;
                        end else begin
                           pos_in = pos_ff + 5'd1;
                        end
                     end else begin
                        new_res              = 1'b1;
                        res_word.field_code  = m2sh_pkg::ext_field_code(pos_ff);
                        res_word.field_value = acc_new;
                        if (pos_ff >= m2sh_pkg::EXT_POS_LAST) begin
                           hunt = 1'b1;
                        end else begin
                           pos_in = pos_ff + 5'd1;
                        end
                     end
                  end else begin
                     hunt = 1'b1;
                  end
               end
            end
            byte_done = hunt || (used_sum == 4'd8);
            used_in   = byte_done ? 3'd0 : used_sum[2:0];
         end
         default: begin
            byte_done = 1'b1;
            hunt      = 1'b1;
         end
      endcase

      // rest of the byte is dropped on a return to hunting; buffer end clears all
      if (hunt || (byte_done && head_item.word.buffer_end)) begin
         mode_in     = MODE_HUNT;
         zero_run_in = 2'd0;
         acc_in      = '0;
         bits_in     = '0;
         pos_in      = '0;
         mcount_in   = '0;
         used_in     = 3'd0;
      end
   end

   // pending result: held until it is known whether it is the byte's last
   always_comb begin
      push      = pend_valid_ff && can_push && (pend_done_ff || (step && new_res));
      push_word = pend_word_ff;
      push_word.last_result = pend_done_ff;
      head_pop  = step && byte_done;

      pend_valid_in = pend_valid_ff;
      pend_done_in  = pend_done_ff;
      pend_word_in  = pend_word_ff;
      if (step && new_res) begin
         pend_valid_in = 1'b1;
         pend_done_in  = byte_done;
         pend_word_in  = res_word;
      end else if (push) begin
         pend_valid_in = 1'b0;
         pend_done_in  = 1'b0;
      end else if (step && byte_done && pend_valid_ff) begin
         pend_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_HUNT;
         zero_run_ff   <= '0;
         acc_ff        <= '0;
         bits_ff       <= '0;
         pos_ff        <= '0;
         mcount_ff     <= '0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_done_ff  <= 1'b0;
      end else begin
         if (step) begin
            mode_ff     <= mode_in;
            zero_run_ff <= zero_run_in;
            acc_ff      <= acc_in;
            bits_ff     <= bits_in;
            pos_ff      <= pos_in;
            mcount_ff   <= mcount_in;
            used_ff     <= used_in;
         end
         pend_valid_ff <= pend_valid_in;
         pend_done_ff  <= pend_done_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_word_ff <= pend_word_in;
   end

endmodule

### sv/m2sh_rsp_queue.sv
module m2sh_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  m2sh_pkg::rsp_word_type push_word,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output m2sh_pkg::rsp_word_type rsp_word
);

   m2sh_pkg::rsp_word_type           mem_ff [m2sh_pkg::QUEUE_DEPTH];
   logic [m2sh_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [m2sh_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [m2sh_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             wr;
   logic                             rd;

   assign full      = (count_ff == m2sh_pkg::QUEUE_CNT_W'(m2sh_pkg::QUEUE_DEPTH));
   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign wr        = push && !full;
   assign rd        = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
